// File: rtl/core/mlstq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted task queue package
// Shared constants, operation codes, controller states and the command and
// status words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mlstq_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int NUM_LISTS_DEF   = 4;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int ID_W            = 4;
    localparam int LIST_FIELD_W    = 2;
    localparam int SORT_KEY_W      = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_MOVE   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_QUEUED    = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UL_READ,
        S_UL_PREV,
        S_UL_NEXT,
        S_UL_FIX,
        S_INS_START,
        S_WALK_REQ,
        S_WALK_CHK,
        S_INS_SELF,
        S_INS_PREV,
        S_INS_NEXT,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;     // capture the input word
        logic decode;       // evaluate head and slot valid
        logic ul_read;      // read the slot to be unlinked
        logic ul_prev;      // read predecessor, patch head if first
        logic ul_next;      // patch predecessor, clear valid
        logic ul_fix;       // patch successor prev pointer
        logic ins_start;    // set up the walk from the list head
        logic walk_req;     // read the current walk slot
        logic walk_step;    // advance the walk by one slot
        logic ins_self;     // write inserted slot, patch head if first
        logic ins_prev;     // patch predecessor
        logic ins_next;     // patch successor
        logic set_result;   // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic id_in_range;  // the addressed slot number exists
        logic id_valid;     // the addressed slot is linked
        logic head_nil;     // the source list is empty
        logic walk_done;    // the walk has found its place
    } stat_t;

endpackage

// File: rtl/core/mlstq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mlstq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/mlstq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted task queue controller
// Sequences the unlink, the sorted walk and the relinking of one word.
// ----------------------------------------------------------------------------
module mlstq_ctrl
    import mlstq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                case (stat.op)
                    OP_INSERT:
                        state_next = (stat.id_in_range && !stat.id_valid) ? S_INS_START
                                                                          : S_DONE;
                    OP_REMOVE:
                        state_next = stat.id_valid ? S_UL_READ : S_DONE;
                    default:
                        state_next = stat.head_nil ? S_DONE : S_UL_READ;
                endcase
            end
            S_UL_READ:
            begin
                cmd.ul_read = 1'b1;
                state_next  = S_UL_PREV;
            end
            S_UL_PREV:
            begin
                cmd.ul_prev = 1'b1;
                state_next  = S_UL_NEXT;
            end
            S_UL_NEXT:
            begin
                cmd.ul_next = 1'b1;
                state_next  = S_UL_FIX;
            end
            S_UL_FIX:
            begin
                cmd.ul_fix = 1'b1;
                state_next = (stat.op == OP_MOVE) ? S_INS_START : S_DONE;
            end
            S_INS_START:
            begin
                cmd.ins_start = 1'b1;
                state_next    = S_WALK_REQ;
            end
            S_WALK_REQ:
            begin
                cmd.walk_req = 1'b1;
                state_next   = stat.walk_done ? S_INS_SELF : S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                cmd.walk_step = 1'b1;
                state_next    = S_WALK_REQ;
            end
            S_INS_SELF:
            begin
                cmd.ins_self = 1'b1;
                state_next   = S_INS_PREV;
            end
            S_INS_PREV:
            begin
                cmd.ins_prev = 1'b1;
                state_next   = S_INS_NEXT;
            end
            S_INS_NEXT:
            begin
                cmd.ins_next = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        cmd.set_result = (state_reg == S_DECODE);
    end

endmodule

// File: rtl/core/mlstq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted task queue datapath
// Slot stores, list heads, walk pointers and the result register.
// ----------------------------------------------------------------------------
module mlstq_dp
    import mlstq_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NUM_LISTS   = NUM_LISTS_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic [1:0]              mode,
    input  logic [LIST_FIELD_W-1:0] list_sel,
    input  logic [LIST_FIELD_W-1:0] dest_list,
    input  logic [ID_W-1:0]         entry_id,
    input  logic [SORT_KEY_W-1:0]   sort_key,
    input  logic                    keep_key,
    output logic [1:0]              status,
    output logic [ID_W-1:0]         out_id,
    output logic [SORT_KEY_W-1:0]   out_key
);

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int PW = SW + 1;                 // pointer with null marker
    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam logic [PW-1:0] NIL = PW'(MAX_ENTRIES);

    // Wrap a list number into range by repeated compare and subtract.
    function automatic logic [LW-1:0] wrap_list(input logic [LIST_FIELD_W-1:0] v);
        int r;
        r = int'(v);
        for (int i = 0; i < (1 << LIST_FIELD_W); i++)
        begin
            if (r >= NUM_LISTS)
            begin
                r = r - NUM_LISTS;
            end
        end
        return LW'(r);
    endfunction

    // Latched input word.
    op_t                  op_reg;
    logic [LW-1:0]        src_reg, dst_reg;
    logic [ID_W-1:0]      id_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 keep_reg;

    // Working registers.
    logic [SW-1:0]        slot_reg;             // slot being moved
    logic [KEY_WIDTH-1:0] ins_key_reg;
    logic [LW-1:0]        ins_list_reg;
    logic [PW-1:0]        bef_reg, cur_reg;
    logic [PW-1:0]        up_reg, un_reg;       // unlink prev and next
    logic [LW-1:0]        ul_list_reg;
    logic [SW:0]          guard_reg;
    logic                 walk_done_reg;

    logic [1:0]           status_reg;
    logic [ID_W-1:0]      oid_reg;
    logic [KEY_WIDTH-1:0] okey_reg;

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [PW-1:0]          head_reg [NUM_LISTS];

    // Slot link record in one memory, key in another.
    localparam int LINK_W = LW + 2 * PW;
    logic                 lk_we, ky_we;
    logic [SW-1:0]        lk_wa, lk_ra;
    logic [LINK_W-1:0]    lk_wd, lk_rd;
    logic [KEY_WIDTH-1:0] ky_wd, ky_rd;

    mlstq_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
        .raddr(lk_ra), .rdata(lk_rd)
    );
    mlstq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_ENTRIES)) u_key (
        .clk(clk), .we(ky_we), .waddr(lk_wa), .wdata(ky_wd),
        .raddr(lk_ra), .rdata(ky_rd)
    );

    logic [LW-1:0] rd_owner;
    logic [PW-1:0] rd_prev, rd_next;
    assign {rd_owner, rd_prev, rd_next} = lk_rd;

    // Successor record with its prev pointer bridged over the unlinked slot.
    logic [LINK_W-1:0] fix_wd;
    assign fix_wd = {rd_owner, up_reg, rd_next};

    logic          id_in_range;
    logic [SW-1:0] id_slot;
    logic [PW-1:0] head_src;
    assign id_in_range = ({{PW{1'b0}}, id_reg} < {{ID_W{1'b0}}, NIL});
    assign id_slot     = SW'(id_reg);
    assign head_src    = head_reg[src_reg];

    always_comb
    begin
        stat.op          = op_reg;
        stat.id_in_range = id_in_range;
        stat.id_valid    = id_in_range && valid_reg[id_slot];
        stat.head_nil    = (head_src == NIL);
        stat.walk_done   = walk_done_reg;
    end

    // Memory addressing and write data.
    always_comb
    begin
        lk_ra = id_slot;
        lk_we = 1'b0;
        ky_we = 1'b0;
        lk_wa = slot_reg;
        lk_wd = {rd_owner, rd_prev, rd_next};
        ky_wd = ins_key_reg;
        if (cmd.decode)
        begin
            lk_ra = (op_reg == OP_INSERT || op_reg == OP_REMOVE) ? id_slot
                                                                 : SW'(head_src);
        end
        else if (cmd.ul_read)
        begin
            lk_ra = slot_reg;
        end
        else if (cmd.ul_prev)
        begin
            // Predecessor next pointer: read-modify-write via second read below.
            lk_ra = SW'(up_reg);
        end
        else if (cmd.ul_next)
        begin
            lk_ra = SW'(un_reg);
            if (up_reg != NIL)
            begin
                lk_we = 1'b1;
                lk_wa = SW'(up_reg);
                lk_wd = {rd_owner, rd_prev, un_reg};
            end
        end
        else if (cmd.ul_fix)
        begin
            if (un_reg != NIL)
            begin
                lk_we = 1'b1;
                lk_wa = SW'(un_reg);
                lk_wd = fix_wd;
            end
        end
        else if (cmd.walk_req)
        begin
            lk_ra = SW'(cur_reg);
        end
        else if (cmd.ins_self)
        begin
            lk_we = 1'b1;
            ky_we = 1'b1;
            lk_wa = slot_reg;
            lk_wd = {ins_list_reg, bef_reg, cur_reg};
            lk_ra = SW'(bef_reg);
        end
        else if (cmd.ins_prev)
        begin
            lk_ra = SW'(cur_reg);
            if (bef_reg != NIL)
            begin
                lk_we = 1'b1;
                lk_wa = SW'(bef_reg);
                lk_wd = {rd_owner, rd_prev, {1'b0, slot_reg}};
            end
        end
        else if (cmd.ins_next)
        begin
            lk_ra = SW'(cur_reg);
            if (cur_reg != NIL)
            begin
                lk_we = 1'b1;
                lk_wa = SW'(cur_reg);
                lk_wd = {rd_owner, {1'b0, slot_reg}, rd_next};
            end
        end
    end

    // Slot valid flags and list heads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= NIL;
            end
        end
        else
        begin
            if (cmd.ul_prev && up_reg == NIL)
            begin
                head_reg[ul_list_reg] <= un_reg;
            end
            if (cmd.ul_next)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
            if (cmd.ins_self)
            begin
                valid_reg[slot_reg] <= 1'b1;
                if (bef_reg == NIL)
                begin
                    head_reg[ins_list_reg] <= {1'b0, slot_reg};
                end
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= op_t'(mode);
            src_reg  <= wrap_list(list_sel);
            dst_reg  <= wrap_list(dest_list);
            id_reg   <= entry_id;
            key_reg  <= KEY_WIDTH'(sort_key);
            keep_reg <= keep_key;
        end
        if (cmd.decode)
        begin
            if (op_reg == OP_INSERT || op_reg == OP_REMOVE)
            begin
                slot_reg <= id_slot;
            end
            else
            begin
                slot_reg <= SW'(head_src);
            end
            ins_list_reg <= (op_reg == OP_MOVE) ? dst_reg : src_reg;
            ins_key_reg  <= key_reg;
        end
        if (cmd.set_result)
        begin
            status_reg <= ST_OK;
            oid_reg    <= id_reg;
            okey_reg   <= key_reg;
            if (op_reg == OP_INSERT || op_reg == OP_REMOVE)
            begin
                if (!id_in_range)
                begin
                    status_reg <= ST_NOT_QUEUED;
                    okey_reg   <= '0;
                end
                else if (op_reg == OP_INSERT && valid_reg[id_slot])
                begin
                    status_reg <= ST_QUEUED;
                end
                else if (op_reg == OP_REMOVE && !valid_reg[id_slot])
                begin
                    status_reg <= ST_NOT_QUEUED;
                    okey_reg   <= '0;
                end
            end
            else if (head_src == NIL)
            begin
                status_reg <= ST_EMPTY;
                oid_reg    <= '0;
                okey_reg   <= '0;
            end
            else
            begin
                oid_reg <= ID_W'(head_src);
            end
        end
        if (cmd.ul_read)
        begin
            // Stored key becomes the result, except for a move that takes a new key.
            up_reg      <= rd_prev;
            un_reg      <= rd_next;
            ul_list_reg <= rd_owner;
            if (status_reg != ST_OK || op_reg != OP_MOVE || keep_reg)
            begin
                okey_reg    <= ky_rd;
                ins_key_reg <= ky_rd;
            end
        end
        if (cmd.ins_start)
        begin
            bef_reg       <= NIL;
            cur_reg       <= head_reg[ins_list_reg];
            guard_reg     <= '0;
            walk_done_reg <= (head_reg[ins_list_reg] == NIL);
            okey_reg      <= ins_key_reg;
        end
        if (cmd.walk_step)
        begin
            if (ky_rd <= ins_key_reg && guard_reg < (SW+1)'(MAX_ENTRIES))
            begin
                bef_reg       <= cur_reg;
                cur_reg       <= rd_next;
                guard_reg     <= guard_reg + 1'b1;
                walk_done_reg <= (rd_next == NIL);
            end
            else
            begin
                walk_done_reg <= 1'b1;
            end
        end
    end

    // An insert of a queued slot reports its stored key. The memory keeps
    // reading that slot until the next word is taken, so the key holds.
    logic qkey_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qkey_reg <= 1'b0;
        end
        else if (cmd.latch_in)
        begin
            qkey_reg <= 1'b0;
        end
        else if (cmd.decode && op_reg == OP_INSERT && stat.id_valid)
        begin
            qkey_reg <= 1'b1;
        end
    end

    assign status  = status_reg;
    assign out_id  = oid_reg;
    assign out_key = qkey_reg ? SORT_KEY_W'(ky_rd) : SORT_KEY_W'(okey_reg);

endmodule

// File: rtl/core/multi_list_sorted_task_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-list sorted task queue
// Several ascending-key lists of task slots sharing one slot pool. One word
// at a time: a word is taken only while idle, and the next not until the
// status word of the last has been taken. A pop or remove unlinks a slot,
// an insert walks its list and links the slot in, and a move does both;
// an insert of a queued slot, an unknown slot or a pop from an empty list
// only reports its status. The walk through the link memory reads one slot
// per compare. Equal keys keep arrival order.
// ----------------------------------------------------------------------------
module multi_list_sorted_task_queue
    import mlstq_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NUM_LISTS   = NUM_LISTS_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              mode,
    input  logic [LIST_FIELD_W-1:0] list_sel,
    input  logic [LIST_FIELD_W-1:0] dest_list,
    input  logic [ID_W-1:0]         entry_id,
    input  logic [SORT_KEY_W-1:0]   sort_key,
    input  logic                    keep_key,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [ID_W-1:0]         out_id,
    output logic [SORT_KEY_W-1:0]   out_key
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    mlstq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    // Stores and pointers.
    mlstq_dp #(
        .MAX_ENTRIES(MAX_ENTRIES), .NUM_LISTS(NUM_LISTS), .KEY_WIDTH(KEY_WIDTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .mode(mode),
        .list_sel(list_sel), .dest_list(dest_list), .entry_id(entry_id),
        .sort_key(sort_key), .keep_key(keep_key), .status(status),
        .out_id(out_id), .out_key(out_key)
    );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted task queue testbench
// Drives insert, pop, move and remove words into the queue, keeps its own
// model of the sorted lists and compares every status word, field by field,
// against the predicted one, under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module tb_top;
    import mlstq_pkg::*;

    localparam int SLOTS     = 16;
    localparam int LISTS     = 4;
    localparam int NIL       = SLOTS;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        op_t         op;
        logic [1:0]  src;
        logic [1:0]  dst;
        logic [3:0]  id;
        logic [31:0] key;
        logic        keep;
    } cmd_word_t;

    typedef struct packed {
        status_t     st;
        logic [3:0]  id;
        logic [31:0] key;
    } res_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [1:0]  list_sel;
    logic [1:0]  dest_list;
    logic [3:0]  entry_id;
    logic [31:0] sort_key;
    logic        keep_key;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [3:0]  out_id;
    logic [31:0] out_key;

    // Model state of the slot pool.
    bit          q_valid [SLOTS];
    logic [1:0]  q_owner [SLOTS];
    logic [31:0] q_key   [SLOTS];
    int          q_next  [SLOTS];
    int          q_prev  [SLOTS];
    int          q_head  [LISTS];

    cmd_word_t   pending_cmds[$];
    res_word_t   expected_res[$];
    int          errors;
    int          idle_in_pct;
    int          idle_out_pct;
    bit          hold_off;
    int          wdog;

    multi_list_sorted_task_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .list_sel  (list_sel),
        .dest_list (dest_list),
        .entry_id  (entry_id),
        .sort_key  (sort_key),
        .keep_key  (keep_key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_id    (out_id),
        .out_key   (out_key)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Unlink a slot from whichever list holds it.
    function automatic void slot_unlink(int s);
        int p;
        int n;
        p = q_prev[s];
        n = q_next[s];
        if (p < NIL)
            q_next[p] = n;
        else
            q_head[q_owner[s]] = n;
        if (n < NIL)
            q_prev[n] = p;
        q_valid[s] = 0;
        q_next[s]  = NIL;
        q_prev[s]  = NIL;
    endfunction

    // Link a slot in after every entry whose key is not greater.
    function automatic void slot_link_sorted(int l, int s, logic [31:0] k);
        int bef;
        int cur;
        bef = NIL;
        cur = q_head[l];
        while (cur < NIL && q_key[cur] <= k)
        begin
            bef = cur;
            cur = q_next[cur];
        end
        q_key[s]   = k;
        q_owner[s] = l[1:0];
        q_prev[s]  = bef;
        q_next[s]  = cur;
        q_valid[s] = 1;
        if (bef < NIL)
            q_next[bef] = s;
        else
            q_head[l] = s;
        if (cur < NIL)
            q_prev[cur] = s;
    endfunction

    // Work out the status word that a command produces and update the lists.
    function automatic res_word_t queue_apply(cmd_word_t c);
        res_word_t r;
        int h;
        logic [31:0] k;
        r = '{st: ST_OK, id: 4'd0, key: 32'd0};
        case (c.op)
            OP_INSERT:
            begin
                r.id = c.id;
                if (q_valid[c.id])
                begin
                    r.st  = ST_QUEUED;
                    r.key = q_key[c.id];
                end
                else
                begin
                    slot_link_sorted(c.src, c.id, c.key);
                    r.key = c.key;
                end
            end
            OP_REMOVE:
            begin
                r.id = c.id;
                if (!q_valid[c.id])
                    r.st = ST_NOT_QUEUED;
                else
                begin
                    r.key = q_key[c.id];
                    slot_unlink(c.id);
                end
            end
            default:
            begin
                h = q_head[c.src];
                if (h >= NIL)
                    r.st = ST_EMPTY;
                else
                begin
                    k = q_key[h];
                    slot_unlink(h);
                    if (c.op == OP_MOVE)
                    begin
                        if (!c.keep)
                            k = c.key;
                        slot_link_sorted(c.dst, h, k);
                    end
                    r.id  = h[3:0];
                    r.key = k;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void push_cmd(op_t op, int src, int dst, int id,
                                     logic [31:0] key, bit keep);
        cmd_word_t c;
        c = '{op: op, src: src[1:0], dst: dst[1:0], id: id[3:0], key: key,
              keep: keep};
        pending_cmds.push_back(c);
    endfunction

    // Random keys drawn mostly from a small range so that ties are common.
    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    function automatic void push_random(int n);
        int i;
        int w;
        for (i = 0; i < n; i++)
        begin
            w = $urandom_range(0, 99);
            if (w < 40)
                push_cmd(OP_INSERT, $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 15), rand_key(), 1'($urandom_range(0, 1)));
            else if (w < 60)
                push_cmd(OP_POP, $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 15), rand_key(), 1'($urandom_range(0, 1)));
            else if (w < 82)
                push_cmd(OP_MOVE, $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 15), rand_key(), 1'($urandom_range(0, 1)));
            else
                push_cmd(OP_REMOVE, $urandom_range(0, 3), $urandom_range(0, 3),
                         $urandom_range(0, 15), rand_key(), 1'($urandom_range(0, 1)));
        end
    endfunction

    // Driver: presents the next pending word and holds it until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_ready)
            in_valid <= 1'b1;
        else if (pending_cmds.size() != 0 && !hold_off
                 && $urandom_range(0, 99) >= idle_in_pct)
        begin
            in_valid  <= 1'b1;
            mode      <= pending_cmds[0].op;
            list_sel  <= pending_cmds[0].src;
            dest_list <= pending_cmds[0].dst;
            entry_id  <= pending_cmds[0].id;
            sort_key  <= pending_cmds[0].key;
            keep_key  <= pending_cmds[0].keep;
            expected_res.push_back(queue_apply(pending_cmds.pop_front()));
        end
        else
            in_valid <= 1'b0;
    end

    // Monitor: compares each accepted status word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        res_word_t e;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_res.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word st=%0d id=%0d key=%h", $time,
                             status, out_id, out_key);
                end
                else
                begin
                    e = expected_res.pop_front();
                    if (status !== e.st || out_id !== e.id || out_key !== e.key)
                    begin
                        errors++;
                        $display({"%0t: mismatch expected st=%0d id=%0d key=%h,",
                                  " got st=%0d id=%0d key=%h"},
                                 $time, e.st, e.id, e.key, status, out_id, out_key);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= idle_out_pct);
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog == WDOG_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int i;
        int ph;
        errors       = 0;
        idle_in_pct  = 0;
        idle_out_pct = 0;
        hold_off     = 0;
        wdog         = 0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        mode         = '0;
        list_sel     = '0;
        dest_list    = '0;
        entry_id     = '0;
        sort_key     = '0;
        keep_key     = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            q_valid[i] = 0;
            q_owner[i] = '0;
            q_key[i]   = '0;
            q_next[i]  = NIL;
            q_prev[i]  = NIL;
        end
        for (i = 0; i < LISTS; i++)
            q_head[i] = NIL;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;

        // Directed: empty lists, key extremes, ties, duplicates, moves of both
        // kinds, a move within one list and removal of absent entries.
        push_cmd(OP_POP,    0, 0, 0,  32'd0, 0);
        push_cmd(OP_MOVE,   3, 1, 0,  32'd5, 0);
        push_cmd(OP_REMOVE, 0, 0, 15, 32'd0, 0);
        push_cmd(OP_INSERT, 0, 0, 0,  32'hFFFF_FFFF, 0);
        push_cmd(OP_INSERT, 0, 0, 1,  32'd0, 0);
        push_cmd(OP_INSERT, 0, 0, 2,  32'd7, 0);
        push_cmd(OP_INSERT, 0, 0, 3,  32'd7, 0);
        push_cmd(OP_INSERT, 3, 0, 2,  32'd9, 0);
        push_cmd(OP_INSERT, 3, 0, 15, 32'hAAAA_5555, 1);
        push_cmd(OP_INSERT, 3, 0, 14, 32'h5555_AAAA, 1);
        push_cmd(OP_POP,    0, 0, 0,  32'd0, 0);
        push_cmd(OP_MOVE,   0, 2, 0,  32'd3, 1);
        push_cmd(OP_MOVE,   0, 2, 0,  32'd3, 0);
        push_cmd(OP_MOVE,   2, 2, 0,  32'hFFFF_FFFF, 0);
        push_cmd(OP_MOVE,   3, 3, 0,  32'd0, 1);
        push_cmd(OP_REMOVE, 0, 0, 15, 32'd0, 0);
        push_cmd(OP_REMOVE, 0, 0, 15, 32'd0, 0);
        push_cmd(OP_REMOVE, 1, 2, 5,  32'd0, 0);
        push_cmd(OP_POP,    3, 0, 0,  32'd0, 0);
        push_cmd(OP_POP,    2, 0, 0,  32'd0, 0);
        push_cmd(OP_POP,    1, 0, 0,  32'd0, 0);

        // Random phases: none, sender idle, receiver stalling, both.
        for (ph = 0; ph < 4; ph++)
        begin
            idle_in_pct  = (ph == 1 || ph == 3) ? 47 : (ph == 2 ? 0 : 0);
            idle_out_pct = (ph == 2 || ph == 3) ? 47 : 0;
            if (ph == 3)
            begin
                idle_in_pct  = 6;
                idle_out_pct = 6;
            end
            push_random(300);
            while (pending_cmds.size() != 0)
                @(posedge clk);
            if (ph == 1)
            begin
                // Hold the sender until every prediction has been checked.
                hold_off = 1;
                while (expected_res.size() != 0)
                    @(posedge clk);
                hold_off = 0;
            end
        end

        while (in_valid || expected_res.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/core/mlstq_pkg.sv
rtl/core/mlstq_ram.sv
rtl/core/mlstq_ctrl.sv
rtl/core/mlstq_dp.sv
rtl/core/multi_list_sorted_task_queue.sv
sim/tb_top.sv
